// ===== sv/owbm_pkg.sv =====
// ----------------------------------------------------------------------------
// owbm_pkg
// Shared types and constants for the one-wire bus master: word formats,
// command codes, sequencer phases and timing register map.
// ----------------------------------------------------------------------------
`default_nettype none

package owbm_pkg;

  localparam int TIMER_WIDTH_DEF = 10;
  localparam int CFG_WIDTH       = 10;
  localparam int NUM_REGS        = 8;
  localparam int REG_IDX_WIDTH   = 3;

  // timing register indexes
  localparam logic [REG_IDX_WIDTH-1:0] REG_RESET_LOW     = 3'd0;
  localparam logic [REG_IDX_WIDTH-1:0] REG_PRESENCE_WAIT = 3'd1;
  localparam logic [REG_IDX_WIDTH-1:0] REG_RESET_REC     = 3'd2;
  localparam logic [REG_IDX_WIDTH-1:0] REG_READ_LOW      = 3'd3;
  localparam logic [REG_IDX_WIDTH-1:0] REG_READ_REC      = 3'd4;
  localparam logic [REG_IDX_WIDTH-1:0] REG_WRITE_LOW     = 3'd5;
  localparam logic [REG_IDX_WIDTH-1:0] REG_WRITE_HOLD    = 3'd6;
  localparam logic [REG_IDX_WIDTH-1:0] REG_WRITE_REC     = 3'd7;

  localparam logic [CFG_WIDTH-1:0] CFG_RESET_VAL [NUM_REGS] = '{
    10'd48, 10'd10, 10'd10, 10'd1, 10'd15, 10'd2, 10'd10, 10'd5
  };

  typedef enum logic [2:0] {
    OP_TICK  = 3'd0,
    OP_RESET = 3'd1,
    OP_WBIT  = 3'd2,
    OP_RBIT  = 3'd3,
    OP_WBYTE = 3'd4,
    OP_RBYTE = 3'd5
  } op_t;

  typedef enum logic [3:0] {
    PH_IDLE      = 4'd0,
    PH_RST_LOW   = 4'd1,
    PH_RST_WAIT  = 4'd2,
    PH_RST_REC   = 4'd3,
    PH_RD_LOW    = 4'd4,
    PH_RD_SAMPLE = 4'd5,
    PH_RD_REC    = 4'd6,
    PH_WR_LOW    = 4'd7,
    PH_WR_HOLD   = 4'd8,
    PH_WR_REC    = 4'd9
  } phase_t;

  typedef struct packed {
    logic [2:0] operation;
    logic [7:0] command_data;
    logic       line_sample;
  } in_word_t;

  typedef struct packed {
    logic       line_drive_enable;
    logic       line_drive_level;
    logic       busy_res;
    logic       done_res;
    logic [7:0] read_data;
    logic       presence_level;
    logic       rejected;
  } out_word_t;

endpackage

`default_nettype wire

// ===== sv/owbm_cfg.sv =====
// ----------------------------------------------------------------------------
// owbm_cfg
// Timing register file. Holds the eight microsecond counts and presents
// each one clamped to the slot timer range.
// ----------------------------------------------------------------------------
`default_nettype none

module owbm_cfg #(
  parameter int TIMER_WIDTH = owbm_pkg::TIMER_WIDTH_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               cfg_wr_en,
  input  wire logic [owbm_pkg::REG_IDX_WIDTH-1:0] cfg_index,
  input  wire logic [owbm_pkg::CFG_WIDTH-1:0]     cfg_wdata,
  output logic      [TIMER_WIDTH-1:0]             tm_load [owbm_pkg::NUM_REGS]
);

  localparam int CW = owbm_pkg::CFG_WIDTH;
  localparam int LW = (TIMER_WIDTH > CW) ? TIMER_WIDTH : CW;
  localparam logic [LW-1:0] TMR_MAX = LW'({TIMER_WIDTH{1'b1}});

  logic [CW-1:0] regs_r [owbm_pkg::NUM_REGS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < owbm_pkg::NUM_REGS; i++) begin
        regs_r[i] <= owbm_pkg::CFG_RESET_VAL[i];
      end
    end else if (cfg_wr_en) begin
      regs_r[cfg_index] <= cfg_wdata;
    end
  end

  for (genvar g = 0; g < owbm_pkg::NUM_REGS; g++) begin : g_sat
    logic [LW-1:0] val_x;
    assign val_x      = LW'(regs_r[g]);
    assign tm_load[g] = (val_x > TMR_MAX) ? {TIMER_WIDTH{1'b1}} : TIMER_WIDTH'(val_x);
  end

endmodule

`default_nettype wire

// ===== sv/owbm_seq.sv =====
// ----------------------------------------------------------------------------
// owbm_seq
// Bus sequencer. Holds the phase, slot timer, bit counter, shift byte and
// line drive state; updates them once per word and forms the result word.
// ----------------------------------------------------------------------------
`default_nettype none

module owbm_seq #(
  parameter int TIMER_WIDTH = owbm_pkg::TIMER_WIDTH_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   step_en,
  input  wire owbm_pkg::in_word_t     item,
  input  wire logic [TIMER_WIDTH-1:0] tm_load [owbm_pkg::NUM_REGS],
  output owbm_pkg::out_word_t         res_nxt
);

  localparam int TW = TIMER_WIDTH;

  owbm_pkg::phase_t phase_r, phase_nxt;
  logic [TW-1:0]    tmr_r, tmr_nxt;
  logic [2:0]       bit_r, bit_nxt;
  logic [7:0]       shift_r, shift_nxt;
  logic [2:0]       kind_r, kind_nxt;
  logic [7:0]       rd_res_r, rd_res_nxt;
  logic             pres_r, pres_nxt;
  logic             de_r, de_nxt;
  logic             dl_r, dl_nxt;

  logic       busy, is_cmd, start, rej, step, expired, more_bits, rd_short, done;
  logic [7:0] shift_smp;
  logic [TW-1:0] rd_rec;

  assign busy     = (phase_r != owbm_pkg::PH_IDLE);
  assign is_cmd   = (item.operation >= owbm_pkg::OP_RESET) &&
                    (item.operation <= owbm_pkg::OP_RBYTE);
  assign start    = is_cmd && !busy;
  assign rej      = is_cmd && busy;
  assign step     = (item.operation == owbm_pkg::OP_TICK) && busy;
  assign expired  = (tmr_r <= TW'(1));
  assign more_bits = ((kind_r == owbm_pkg::OP_WBYTE) || (kind_r == owbm_pkg::OP_RBYTE)) &&
                     (bit_r != 3'd7);
  assign rd_rec   = tm_load[owbm_pkg::REG_READ_REC];
  assign rd_short = (rd_rec <= TW'(1));
  assign shift_smp = shift_r | (8'(item.line_sample) << bit_r);

  // next phase
  always_comb begin
    phase_nxt = phase_r;
    if (start) begin
      case (item.operation)
        owbm_pkg::OP_RESET: phase_nxt = owbm_pkg::PH_RST_LOW;
        owbm_pkg::OP_WBIT,
        owbm_pkg::OP_WBYTE: phase_nxt = owbm_pkg::PH_WR_LOW;
        default:            phase_nxt = owbm_pkg::PH_RD_LOW;
      endcase
    end else if (step) begin
      case (phase_r)
        owbm_pkg::PH_RST_LOW:   if (expired) phase_nxt = owbm_pkg::PH_RST_WAIT;
        owbm_pkg::PH_RST_WAIT:  if (expired) phase_nxt = owbm_pkg::PH_RST_REC;
        owbm_pkg::PH_RST_REC:   if (expired) phase_nxt = owbm_pkg::PH_IDLE;
        owbm_pkg::PH_RD_LOW:    if (expired) phase_nxt = owbm_pkg::PH_RD_SAMPLE;
        owbm_pkg::PH_RD_SAMPLE: begin
          if (!rd_short)      phase_nxt = owbm_pkg::PH_RD_REC;
          else if (more_bits) phase_nxt = owbm_pkg::PH_RD_LOW;
          else                phase_nxt = owbm_pkg::PH_IDLE;
        end
        owbm_pkg::PH_RD_REC: begin
          if (expired) phase_nxt = more_bits ? owbm_pkg::PH_RD_LOW : owbm_pkg::PH_IDLE;
        end
        owbm_pkg::PH_WR_LOW:    if (expired) phase_nxt = owbm_pkg::PH_WR_HOLD;
        owbm_pkg::PH_WR_HOLD:   if (expired) phase_nxt = owbm_pkg::PH_WR_REC;
        owbm_pkg::PH_WR_REC: begin
          if (expired) phase_nxt = more_bits ? owbm_pkg::PH_WR_LOW : owbm_pkg::PH_IDLE;
        end
        default: phase_nxt = owbm_pkg::PH_IDLE;
      endcase
    end
  end

  // datapath and flags
  always_comb begin
    tmr_nxt    = tmr_r;
    bit_nxt    = bit_r;
    shift_nxt  = shift_r;
    kind_nxt   = kind_r;
    rd_res_nxt = rd_res_r;
    pres_nxt   = pres_r;
    de_nxt     = de_r;
    dl_nxt     = dl_r;
    done       = 1'b0;
    if (start) begin
      kind_nxt = item.operation;
      bit_nxt  = 3'd0;
      de_nxt   = 1'b1;
      dl_nxt   = 1'b0;
      case (item.operation)
        owbm_pkg::OP_RESET: tmr_nxt = tm_load[owbm_pkg::REG_RESET_LOW];
        owbm_pkg::OP_WBIT: begin
          shift_nxt = {7'd0, item.command_data[0]};
          tmr_nxt   = tm_load[owbm_pkg::REG_WRITE_LOW];
        end
        owbm_pkg::OP_WBYTE: begin
          shift_nxt = item.command_data;
          tmr_nxt   = tm_load[owbm_pkg::REG_WRITE_LOW];
        end
        default: begin
          shift_nxt = 8'd0;
          tmr_nxt   = tm_load[owbm_pkg::REG_READ_LOW];
        end
      endcase
    end else if (step) begin
      if (!expired) tmr_nxt = tmr_r - TW'(1);
      case (phase_r)
        owbm_pkg::PH_RST_LOW: begin
          if (expired) begin
            de_nxt  = 1'b0;
            dl_nxt  = 1'b1;
            tmr_nxt = tm_load[owbm_pkg::REG_PRESENCE_WAIT];
          end
        end
        owbm_pkg::PH_RST_WAIT: begin
          if (expired) begin
            pres_nxt = item.line_sample;
            tmr_nxt  = tm_load[owbm_pkg::REG_RESET_REC];
          end
        end
        owbm_pkg::PH_RST_REC: done = expired;
        owbm_pkg::PH_RD_LOW: begin
          if (expired) begin
            de_nxt = 1'b0;
            dl_nxt = 1'b1;
          end
        end
        owbm_pkg::PH_RD_SAMPLE: begin
          shift_nxt = shift_smp;
          if (!rd_short) begin
            tmr_nxt = rd_rec - TW'(1);
          end else if (more_bits) begin
            bit_nxt = bit_r + 3'd1;
            de_nxt  = 1'b1;
            dl_nxt  = 1'b0;
            tmr_nxt = tm_load[owbm_pkg::REG_READ_LOW];
          end else begin
            rd_res_nxt = shift_smp;
            done       = 1'b1;
          end
        end
        owbm_pkg::PH_RD_REC: begin
          if (expired) begin
            if (more_bits) begin
              bit_nxt = bit_r + 3'd1;
              de_nxt  = 1'b1;
              dl_nxt  = 1'b0;
              tmr_nxt = tm_load[owbm_pkg::REG_READ_LOW];
            end else begin
              rd_res_nxt = shift_r;
              done       = 1'b1;
            end
          end
        end
        owbm_pkg::PH_WR_LOW: begin
          if (expired) begin
            dl_nxt  = shift_r[0];
            tmr_nxt = tm_load[owbm_pkg::REG_WRITE_HOLD];
          end
        end
        owbm_pkg::PH_WR_HOLD: begin
          if (expired) begin
            dl_nxt  = 1'b1;
            tmr_nxt = tm_load[owbm_pkg::REG_WRITE_REC];
          end
        end
        owbm_pkg::PH_WR_REC: begin
          if (expired) begin
            if (more_bits) begin
              bit_nxt   = bit_r + 3'd1;
              shift_nxt = shift_r >> 1;
              de_nxt    = 1'b1;
              dl_nxt    = 1'b0;
              tmr_nxt   = tm_load[owbm_pkg::REG_WRITE_LOW];
            end else begin
              done = 1'b1;
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    res_nxt.line_drive_enable = de_nxt;
    res_nxt.line_drive_level  = dl_nxt;
    res_nxt.busy_res          = (phase_nxt != owbm_pkg::PH_IDLE);
    res_nxt.done_res          = done;
    res_nxt.read_data         = rd_res_nxt;
    res_nxt.presence_level    = pres_nxt;
    res_nxt.rejected          = rej;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= owbm_pkg::PH_IDLE;
      tmr_r    <= '0;
      bit_r    <= '0;
      shift_r  <= '0;
      kind_r   <= '0;
      rd_res_r <= '0;
      pres_r   <= 1'b1;
      de_r     <= 1'b1;
      dl_r     <= 1'b1;
    end else if (step_en) begin
      phase_r  <= phase_nxt;
      tmr_r    <= tmr_nxt;
      bit_r    <= bit_nxt;
      shift_r  <= shift_nxt;
      kind_r   <= kind_nxt;
      rd_res_r <= rd_res_nxt;
      pres_r   <= pres_nxt;
      de_r     <= de_nxt;
      dl_r     <= dl_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== sv/one_wire_bus_master_unit.sv =====
// ----------------------------------------------------------------------------
// one_wire_bus_master_unit
// One-wire bus master driven by command and microsecond tick words.
//
// Input words carry either a command (reset/presence, write bit, read bit,
// write byte, read byte) or a tick that advances time by one microsecond
// and brings the sampled line level. Every input word yields exactly one
// result word: line drive enable and level, busy, done, last read data,
// presence level, and a rejected flag for a command that came while busy.
// Timing counts come from eight registers on the cfg_ port; write them only
// while no words are in flight.
//
// An accepted word passes through the input register, then the result
// register, before its result is valid; one word per cycle is sustained
// while out_stall is low. The sequencer state updates in the same cycle
// that moves a word from the input register into the result register.
// A stalled result holds in the output register; the input register keeps
// taking a word as long as its content can move on, so in_stall rises only
// when both stages are full. Synchronous reset empties both stages, sets
// the timing registers to their defaults and leaves the line driven high.
// ----------------------------------------------------------------------------
`default_nettype none

module one_wire_bus_master_unit #(
  parameter int TIMER_WIDTH = owbm_pkg::TIMER_WIDTH_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_valid,
  output logic                                    in_stall,
  input  wire owbm_pkg::in_word_t                 in_data,
  output logic                                    out_valid,
  input  wire logic                               out_stall,
  output owbm_pkg::out_word_t                     out_data,
  input  wire logic                               cfg_wr_en,
  input  wire logic [owbm_pkg::REG_IDX_WIDTH-1:0] cfg_index,
  input  wire logic [owbm_pkg::CFG_WIDTH-1:0]     cfg_wdata
);

  logic                in_vld_r;
  owbm_pkg::in_word_t  in_word_r;
  logic                out_vld_r;
  owbm_pkg::out_word_t out_word_r;
  owbm_pkg::out_word_t res_nxt;
  logic                advance;
  logic                in_take;
  logic [TIMER_WIDTH-1:0] tm_load [owbm_pkg::NUM_REGS];

  assign advance  = in_vld_r && (!out_vld_r || !out_stall);
  assign in_take  = in_valid && !in_stall;
  assign in_stall = in_vld_r && !advance;

  owbm_cfg #(
    .TIMER_WIDTH(TIMER_WIDTH)
  ) u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_wr_en(cfg_wr_en),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata),
    .tm_load  (tm_load)
  );

  owbm_seq #(
    .TIMER_WIDTH(TIMER_WIDTH)
  ) u_seq (
    .clk    (clk),
    .rst_n  (rst_n),
    .step_en(advance),
    .item   (in_word_r),
    .tm_load(tm_load),
    .res_nxt(res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_take) begin
      in_vld_r <= 1'b1;
    end else if (advance) begin
      in_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_word_r <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (advance) begin
      out_vld_r <= 1'b1;
    end else if (!out_stall) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_word_r <= res_nxt;
    end
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_word_r;

endmodule

`default_nettype wire
